/* design/segment_endpoint_corner_picker_defines.svh */
// Assertion macros for the segment endpoint corner picker.
// Taken in by the top level; no other dependencies.
`ifndef SEGMENT_ENDPOINT_CORNER_PICKER_DEFINES_SVH
`define SEGMENT_ENDPOINT_CORNER_PICKER_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rstn is low
`define SEPC_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("sepc assertion failed");

// next-cycle implication, sampled on clk, off while rstn is low
`define SEPC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("sepc assertion failed");

`endif

/* design/sepc_pkg.sv */
// Shared constants and types for the segment endpoint corner picker.
// No dependencies; used by sepc_lane, sepc_merge and the top level.
`default_nettype none

package sepc_pkg;

    localparam int COORD_BITS   = 12;
    localparam int MIN_SEGMENTS = 4;
    localparam int CORNERS      = 4;
    localparam int SQ_BITS      = 2 * COORD_BITS;
    localparam int DIST_BITS    = 2 * COORD_BITS + 1;
    localparam int CNT_BITS     = $clog2(MIN_SEGMENTS + 1);
    localparam int PIPE_DEPTH   = 4;
    localparam int CFG_ADDR_BITS = 2;
    localparam int CFG_DATA_BITS = COORD_BITS;

    localparam logic [COORD_BITS-1:0] SIZE_RESET = COORD_BITS'(400);

    localparam logic [CFG_ADDR_BITS-1:0] REG_IMAGE_WIDTH  = CFG_ADDR_BITS'(0);
    localparam logic [CFG_ADDR_BITS-1:0] REG_IMAGE_HEIGHT = CFG_ADDR_BITS'(1);

    localparam int CORNER_TL = 0;
    localparam int CORNER_TR = 1;
    localparam int CORNER_BR = 2;
    localparam int CORNER_BL = 3;

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic [DIST_BITS-1:0]  dist_t;
    typedef logic [SQ_BITS-1:0]    sq_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
    } point_t;

    typedef struct packed {
        logic advance;
        logic take;
        logic last;
    } lane_ctl_t;

    function automatic coord_t abs_diff(input coord_t a, input coord_t b);
        return (a >= b) ? (a - b) : (b - a);
    endfunction

endpackage

`default_nettype wire

/* design/sepc_lane.sv */
// One corner lane: distance pipeline for both endpoints and the kept minimum.
// Depends on sepc_pkg.
`default_nettype none

module sepc_lane (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire sepc_pkg::lane_ctl_t ctl,
    input  wire sepc_pkg::point_t   corner,
    input  wire sepc_pkg::point_t   p0,
    input  wire sepc_pkg::point_t   p1,
    output sepc_pkg::point_t        best_out
);

    sepc_pkg::point_t p0_s1_reg, p1_s1_reg, p0_s2_reg, p1_s2_reg, p0_s3_reg, p1_s3_reg;
    sepc_pkg::coord_t dx0_s1_reg, dy0_s1_reg, dx1_s1_reg, dy1_s1_reg;
    sepc_pkg::sq_t    sx0_s2_reg, sy0_s2_reg, sx1_s2_reg, sy1_s2_reg;
    sepc_pkg::dist_t  d0_s3_reg, d1_s3_reg;
    sepc_pkg::point_t cand_s4_reg;
    sepc_pkg::dist_t  cand_d_s4_reg;
    sepc_pkg::point_t best_pt_reg, best_pt_next;
    sepc_pkg::dist_t  best_d_reg, best_d_next;
    logic             hit;

    always_ff @(posedge aclk) begin
        if (ctl.advance) begin
            p0_s1_reg  <= p0;
            p1_s1_reg  <= p1;
            dx0_s1_reg <= sepc_pkg::abs_diff(p0.x, corner.x);
            dy0_s1_reg <= sepc_pkg::abs_diff(p0.y, corner.y);
            dx1_s1_reg <= sepc_pkg::abs_diff(p1.x, corner.x);
            dy1_s1_reg <= sepc_pkg::abs_diff(p1.y, corner.y);

            p0_s2_reg  <= p0_s1_reg;
            p1_s2_reg  <= p1_s1_reg;
            sx0_s2_reg <= sepc_pkg::SQ_BITS'(dx0_s1_reg) * sepc_pkg::SQ_BITS'(dx0_s1_reg);
            sy0_s2_reg <= sepc_pkg::SQ_BITS'(dy0_s1_reg) * sepc_pkg::SQ_BITS'(dy0_s1_reg);
            sx1_s2_reg <= sepc_pkg::SQ_BITS'(dx1_s1_reg) * sepc_pkg::SQ_BITS'(dx1_s1_reg);
            sy1_s2_reg <= sepc_pkg::SQ_BITS'(dy1_s1_reg) * sepc_pkg::SQ_BITS'(dy1_s1_reg);

            p0_s3_reg  <= p0_s2_reg;
            p1_s3_reg  <= p1_s2_reg;
            d0_s3_reg  <= sepc_pkg::DIST_BITS'(sx0_s2_reg) + sepc_pkg::DIST_BITS'(sy0_s2_reg);
            d1_s3_reg  <= sepc_pkg::DIST_BITS'(sx1_s2_reg) + sepc_pkg::DIST_BITS'(sy1_s2_reg);

            // second endpoint wins only when strictly closer
            if (d1_s3_reg < d0_s3_reg) begin
                cand_s4_reg   <= p1_s3_reg;
                cand_d_s4_reg <= d1_s3_reg;
            end else begin
                cand_s4_reg   <= p0_s3_reg;
                cand_d_s4_reg <= d0_s3_reg;
            end
        end
    end

    assign hit      = (cand_d_s4_reg < best_d_reg);
    assign best_out = hit ? cand_s4_reg : best_pt_reg;

    always_comb begin
        best_pt_next = best_pt_reg;
        best_d_next  = best_d_reg;
        if (ctl.advance && ctl.take) begin
            if (ctl.last) begin
                best_pt_next = '0;
                best_d_next  = '1;
            end else if (hit) begin
                best_pt_next = cand_s4_reg;
                best_d_next  = cand_d_s4_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_pt_reg <= '0;
            best_d_reg  <= '1;
        end else begin
            best_pt_reg <= best_pt_next;
            best_d_reg  <= best_d_next;
        end
    end

endmodule

`default_nettype wire

/* design/sepc_merge.sv */
// Merge stage: segment count, found flag and the result register.
// Depends on sepc_pkg.
`default_nettype none

module sepc_merge (
    input  wire logic                                    aclk,
    input  wire logic                                    aresetn,
    input  wire sepc_pkg::lane_ctl_t                     ctl,
    input  wire sepc_pkg::point_t [sepc_pkg::CORNERS-1:0] lane_best,
    input  wire logic                                    m_ready,
    output logic                                         out_busy,
    output logic                                         out_valid,
    output logic                                         out_found,
    output sepc_pkg::point_t [sepc_pkg::CORNERS-1:0]     out_corner
);

    logic [sepc_pkg::CNT_BITS-1:0] count_reg, count_next, count_plus;
    logic                          found_now;
    logic                          load;
    logic                          valid_reg, valid_next;
    logic                          found_reg;
    sepc_pkg::point_t [sepc_pkg::CORNERS-1:0] corner_reg;

    assign count_plus = (count_reg < sepc_pkg::CNT_BITS'(sepc_pkg::MIN_SEGMENTS))
                        ? count_reg + sepc_pkg::CNT_BITS'(1) : count_reg;
    assign found_now  = (count_plus >= sepc_pkg::CNT_BITS'(sepc_pkg::MIN_SEGMENTS));
    assign load       = ctl.advance && ctl.take && ctl.last;

    always_comb begin
        count_next = count_reg;
        if (ctl.advance && ctl.take) begin
            count_next = ctl.last ? '0 : count_plus;
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            found_reg  <= found_now;
            corner_reg <= found_now ? lane_best : '0;
        end
    end

    assign out_busy   = valid_reg && !m_ready;
    assign out_valid  = valid_reg;
    assign out_found  = found_reg;
    assign out_corner = corner_reg;

endmodule

`default_nettype wire

/* design/segment_endpoint_corner_picker.sv */
// Top level of the segment endpoint corner picker: config registers,
// four corner lanes and the merge stage. Depends on sepc_pkg, sepc_lane,
// sepc_merge and segment_endpoint_corner_picker_defines.svh.
//
//   channel | handshake         | payload
//   --------+-------------------+--------------------------------------------
//   s_      | s_valid / s_ready | start_x/y, end_x/y, final_segment
//   m_      | m_valid / m_ready | found, four corners as x/y
//   cfg_    | cfg_wr_en         | cfg_addr, cfg_wdata (width, height)
//
// One word per cycle while s_ready is high; the four corner lanes run side
// by side in a four-stage distance pipeline (abs diff, square, sum, endpoint
// pick). A result reaches m_ once its final word leaves the last stage.
// s_ready drops only while a final word sits at the lane outputs and the
// previous result is still held. aresetn clears counters, kept corners,
// valid flags, and sets width and height to 400.
`default_nettype none
`include "segment_endpoint_corner_picker_defines.svh"

module segment_endpoint_corner_picker (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic [sepc_pkg::COORD_BITS-1:0]      s_start_x,
    input  wire logic [sepc_pkg::COORD_BITS-1:0]      s_start_y,
    input  wire logic [sepc_pkg::COORD_BITS-1:0]      s_end_x,
    input  wire logic [sepc_pkg::COORD_BITS-1:0]      s_end_y,
    input  wire logic                                 s_final_segment,
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic                                      m_found,
    output logic [sepc_pkg::COORD_BITS-1:0]           m_top_left_x,
    output logic [sepc_pkg::COORD_BITS-1:0]           m_top_left_y,
    output logic [sepc_pkg::COORD_BITS-1:0]           m_top_right_x,
    output logic [sepc_pkg::COORD_BITS-1:0]           m_top_right_y,
    output logic [sepc_pkg::COORD_BITS-1:0]           m_bottom_right_x,
    output logic [sepc_pkg::COORD_BITS-1:0]           m_bottom_right_y,
    output logic [sepc_pkg::COORD_BITS-1:0]           m_bottom_left_x,
    output logic [sepc_pkg::COORD_BITS-1:0]           m_bottom_left_y,
    input  wire logic                                 cfg_wr_en,
    input  wire logic [sepc_pkg::CFG_ADDR_BITS-1:0]   cfg_addr,
    input  wire logic [sepc_pkg::CFG_DATA_BITS-1:0]   cfg_wdata
);

    sepc_pkg::coord_t width_reg, width_next, height_reg, height_next;
    logic [sepc_pkg::PIPE_DEPTH-1:0] valid_pipe_reg, valid_pipe_next;
    logic [sepc_pkg::PIPE_DEPTH-1:0] last_pipe_reg, last_pipe_next;
    logic                advance;
    logic                out_busy;
    logic                final_take;
    sepc_pkg::lane_ctl_t ctl;
    sepc_pkg::point_t    p0, p1;
    sepc_pkg::point_t [sepc_pkg::CORNERS-1:0] corner_pt;
    sepc_pkg::point_t [sepc_pkg::CORNERS-1:0] lane_best;
    sepc_pkg::point_t [sepc_pkg::CORNERS-1:0] out_corner;

    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_wr_en) begin
            unique case (cfg_addr)
                sepc_pkg::REG_IMAGE_WIDTH:  width_next  = cfg_wdata;
                sepc_pkg::REG_IMAGE_HEIGHT: height_next = cfg_wdata;
                default: ;
            endcase
        end
    end

    // hold the pipeline, lanes and segment count while a final word meets a held result
    assign advance = !(valid_pipe_reg[sepc_pkg::PIPE_DEPTH-1]
                       && last_pipe_reg[sepc_pkg::PIPE_DEPTH-1] && out_busy);
    assign s_ready = advance;

    always_comb begin
        valid_pipe_next = valid_pipe_reg;
        last_pipe_next  = last_pipe_reg;
        if (advance) begin
            valid_pipe_next = {valid_pipe_reg[sepc_pkg::PIPE_DEPTH-2:0], s_valid};
            last_pipe_next  = {last_pipe_reg[sepc_pkg::PIPE_DEPTH-2:0],
                               s_valid && s_final_segment};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg      <= sepc_pkg::SIZE_RESET;
            height_reg     <= sepc_pkg::SIZE_RESET;
            valid_pipe_reg <= '0;
            last_pipe_reg  <= '0;
        end else begin
            width_reg      <= width_next;
            height_reg     <= height_next;
            valid_pipe_reg <= valid_pipe_next;
            last_pipe_reg  <= last_pipe_next;
        end
    end

    assign ctl.advance = advance;
    assign ctl.take    = valid_pipe_reg[sepc_pkg::PIPE_DEPTH-1];
    assign ctl.last    = last_pipe_reg[sepc_pkg::PIPE_DEPTH-1];
    assign final_take  = advance && ctl.take && ctl.last;

    assign p0.x = s_start_x;
    assign p0.y = s_start_y;
    assign p1.x = s_end_x;
    assign p1.y = s_end_y;

    assign corner_pt[sepc_pkg::CORNER_TL].x = '0;
    assign corner_pt[sepc_pkg::CORNER_TL].y = '0;
    assign corner_pt[sepc_pkg::CORNER_TR].x = width_reg;
    assign corner_pt[sepc_pkg::CORNER_TR].y = '0;
    assign corner_pt[sepc_pkg::CORNER_BR].x = width_reg;
    assign corner_pt[sepc_pkg::CORNER_BR].y = height_reg;
    assign corner_pt[sepc_pkg::CORNER_BL].x = '0;
    assign corner_pt[sepc_pkg::CORNER_BL].y = height_reg;

    for (genvar c = 0; c < sepc_pkg::CORNERS; c++) begin : g_lane
        sepc_lane u_lane (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctl      (ctl),
            .corner   (corner_pt[c]),
            .p0       (p0),
            .p1       (p1),
            .best_out (lane_best[c])
        );
    end

    sepc_merge u_merge (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (ctl),
        .lane_best  (lane_best),
        .m_ready    (m_ready),
        .out_busy   (out_busy),
        .out_valid  (m_valid),
        .out_found  (m_found),
        .out_corner (out_corner)
    );

    assign m_top_left_x     = out_corner[sepc_pkg::CORNER_TL].x;
    assign m_top_left_y     = out_corner[sepc_pkg::CORNER_TL].y;
    assign m_top_right_x    = out_corner[sepc_pkg::CORNER_TR].x;
    assign m_top_right_y    = out_corner[sepc_pkg::CORNER_TR].y;
    assign m_bottom_right_x = out_corner[sepc_pkg::CORNER_BR].x;
    assign m_bottom_right_y = out_corner[sepc_pkg::CORNER_BR].y;
    assign m_bottom_left_x  = out_corner[sepc_pkg::CORNER_BL].x;
    assign m_bottom_left_y  = out_corner[sepc_pkg::CORNER_BL].y;

    `SEPC_ASSERT_NOW(a_stall_has_result, aclk, aresetn, !s_ready, m_valid && !m_ready)
    `SEPC_ASSERT_NOW(a_result_from_final, aclk, aresetn, $rose(m_valid), $past(final_take))
    `SEPC_ASSERT_NOW(a_not_found_zero, aclk, aresetn, m_valid && !m_found, out_corner == '0)

endmodule

`default_nettype wire

/* sim/testbench.sv */
// Testbench for segment_endpoint_corner_picker: streams segment words in frames, predicts
// each result in-bench or takes a typed one, and checks every result word field by field.
// Depends on sepc_pkg and the segment_endpoint_corner_picker RTL.
module testbench;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int SETTLE_CYCLES   = 12;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 165;

    localparam logic [sepc_pkg::CFG_ADDR_BITS-1:0] REG_SPARE_LO =
        sepc_pkg::CFG_ADDR_BITS'(2);
    localparam logic [sepc_pkg::CFG_ADDR_BITS-1:0] REG_SPARE_HI =
        sepc_pkg::CFG_ADDR_BITS'(3);

    typedef struct packed {
        sepc_pkg::coord_t sx;
        sepc_pkg::coord_t sy;
        sepc_pkg::coord_t ex;
        sepc_pkg::coord_t ey;
        logic             last;
    } segment_t;

    typedef struct packed {
        logic                                     found;
        sepc_pkg::coord_t [sepc_pkg::CORNERS-1:0] cx;
        sepc_pkg::coord_t [sepc_pkg::CORNERS-1:0] cy;
    } corners_t;

    typedef struct packed {
        segment_t w;
        logic     typed;
        corners_t want;
    } stim_row_t;

    logic   aclk = 1'b0;
    logic   aresetn = 1'b0;
    logic   s_valid = 1'b0;
    logic   s_ready;
    sepc_pkg::coord_t s_start_x = '0;
    sepc_pkg::coord_t s_start_y = '0;
    sepc_pkg::coord_t s_end_x = '0;
    sepc_pkg::coord_t s_end_y = '0;
    logic   s_final_segment = 1'b0;
    logic   m_valid;
    logic   m_ready = 1'b0;
    logic   m_found;
    sepc_pkg::coord_t m_top_left_x, m_top_left_y, m_top_right_x, m_top_right_y;
    sepc_pkg::coord_t m_bottom_right_x, m_bottom_right_y, m_bottom_left_x, m_bottom_left_y;
    logic   cfg_wr_en = 1'b0;
    logic [sepc_pkg::CFG_ADDR_BITS-1:0] cfg_addr = '0;
    logic [sepc_pkg::CFG_DATA_BITS-1:0] cfg_wdata = '0;

    sepc_pkg::coord_t img_w, img_h;
    sepc_pkg::coord_t keep_x [sepc_pkg::CORNERS];
    sepc_pkg::coord_t keep_y [sepc_pkg::CORNERS];
    sepc_pkg::dist_t  keep_d [sepc_pkg::CORNERS];
    logic [2:0] seg_seen;
    corners_t  pending_corners [$];
    stim_row_t directed [$];
    int        errors = 0;
    int        cycle_count = 0;
    int        src_idle_pct = 0;
    int        sink_stall_pct = 0;
    string     corner_name [sepc_pkg::CORNERS] =
        '{"top_left", "top_right", "bottom_right", "bottom_left"};

    segment_endpoint_corner_picker u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_start_x        (s_start_x),
        .s_start_y        (s_start_y),
        .s_end_x          (s_end_x),
        .s_end_y          (s_end_y),
        .s_final_segment  (s_final_segment),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_found          (m_found),
        .m_top_left_x     (m_top_left_x),
        .m_top_left_y     (m_top_left_y),
        .m_top_right_x    (m_top_right_x),
        .m_top_right_y    (m_top_right_y),
        .m_bottom_right_x (m_bottom_right_x),
        .m_bottom_right_y (m_bottom_right_y),
        .m_bottom_left_x  (m_bottom_left_x),
        .m_bottom_left_y  (m_bottom_left_y),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_addr         (cfg_addr),
        .cfg_wdata        (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic void clear_frame();
        for (int c = 0; c < sepc_pkg::CORNERS; c++) begin
            keep_x[c] = '0;
            keep_y[c] = '0;
            keep_d[c] = '1;
        end
        seg_seen = '0;
    endfunction

    function automatic void weigh_point(input sepc_pkg::coord_t px, input sepc_pkg::coord_t py);
        sepc_pkg::coord_t kx, ky;
        sepc_pkg::dist_t  dx, dy, d;
        for (int c = 0; c < sepc_pkg::CORNERS; c++) begin
            kx = (c == sepc_pkg::CORNER_TR || c == sepc_pkg::CORNER_BR) ? img_w : '0;
            ky = (c == sepc_pkg::CORNER_BR || c == sepc_pkg::CORNER_BL) ? img_h : '0;
            dx = (px >= kx) ? sepc_pkg::dist_t'(px - kx) : sepc_pkg::dist_t'(kx - px);
            dy = (py >= ky) ? sepc_pkg::dist_t'(py - ky) : sepc_pkg::dist_t'(ky - py);
            d = dx * dx + dy * dy;
            if (d < keep_d[c]) begin
                keep_d[c] = d;
                keep_x[c] = px;
                keep_y[c] = py;
            end
        end
    endfunction

    function automatic logic take_segment(input segment_t w, output corners_t r);
        weigh_point(w.sx, w.sy);
        weigh_point(w.ex, w.ey);
        if (seg_seen < sepc_pkg::MIN_SEGMENTS) seg_seen = seg_seen + 3'd1;
        r = '0;
        if (!w.last) return 1'b0;
        r.found = (seg_seen >= sepc_pkg::MIN_SEGMENTS);
        if (r.found) begin
            for (int c = 0; c < sepc_pkg::CORNERS; c++) begin
                r.cx[c] = keep_x[c];
                r.cy[c] = keep_y[c];
            end
        end
        clear_frame();
        return 1'b1;
    endfunction

    function automatic sepc_pkg::coord_t pick_coord(input sepc_pkg::coord_t far_edge);
        int v;
        case ($urandom_range(3))
            0: v = $urandom_range(4095);
            1: v = $urandom_range(15);
            2: v = int'(far_edge) + int'($urandom_range(16)) - 8;
            default: begin
                case ($urandom_range(2))
                    0: v = 0;
                    1: v = 4095;
                    default: v = int'(far_edge);
                endcase
            end
        endcase
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
        return sepc_pkg::coord_t'(v);
    endfunction

    function automatic void add_row(input int sx, input int sy, input int ex, input int ey,
                                    input logic last, input logic typed, input corners_t want);
        stim_row_t row;
        row.w = '{sx: sepc_pkg::coord_t'(sx), sy: sepc_pkg::coord_t'(sy),
                  ex: sepc_pkg::coord_t'(ex), ey: sepc_pkg::coord_t'(ey), last: last};
        row.typed = typed;
        row.want = want;
        directed = {directed, row};
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch on %s: got %0d, expected %0d (cycle %0d)", what, got, want,
                 cycle_count);
        errors++;
    endtask

    task automatic send_word(input segment_t w, input logic typed, input corners_t want);
        corners_t r;
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_start_x <= w.sx;
        s_start_y <= w.sy;
        s_end_x <= w.ex;
        s_end_y <= w.ey;
        s_final_segment <= w.last;
        do @(posedge aclk); while (!s_ready);
        if (take_segment(w, r)) pending_corners = {pending_corners, (typed ? want : r)};
    endtask

    task automatic drain(input int settle);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_corners.size() != 0) @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [sepc_pkg::CFG_ADDR_BITS-1:0] idx,
                             input sepc_pkg::coord_t val);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == sepc_pkg::REG_IMAGE_WIDTH) img_w = val;
        else if (idx == sepc_pkg::REG_IMAGE_HEIGHT) img_h = val;
        @(posedge aclk);
    endtask

    always @(posedge aclk) m_ready <= ($urandom_range(99) >= sink_stall_pct);

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("segment_endpoint_corner_picker test failed");
            $finish;
        end
    end

    always @(posedge aclk) begin : result_check
        corners_t got, want;
        if (aresetn && m_valid && m_ready) begin
            got.found = m_found;
            got.cx[sepc_pkg::CORNER_TL] = m_top_left_x;
            got.cy[sepc_pkg::CORNER_TL] = m_top_left_y;
            got.cx[sepc_pkg::CORNER_TR] = m_top_right_x;
            got.cy[sepc_pkg::CORNER_TR] = m_top_right_y;
            got.cx[sepc_pkg::CORNER_BR] = m_bottom_right_x;
            got.cy[sepc_pkg::CORNER_BR] = m_bottom_right_y;
            got.cx[sepc_pkg::CORNER_BL] = m_bottom_left_x;
            got.cy[sepc_pkg::CORNER_BL] = m_bottom_left_y;
            if (pending_corners.size() == 0) begin
                report_mismatch("result word with none pending", 1, 0);
            end else begin
                want = pending_corners.pop_front();
                if (got.found !== want.found) report_mismatch("found", got.found, want.found);
                for (int c = 0; c < sepc_pkg::CORNERS; c++) begin
                    if (got.cx[c] !== want.cx[c])
                        report_mismatch({corner_name[c], "_x"}, got.cx[c], want.cx[c]);
                    if (got.cy[c] !== want.cy[c])
                        report_mismatch({corner_name[c], "_y"}, got.cy[c], want.cy[c]);
                end
            end
        end
    end

    initial begin : main
        corners_t want_square;
        segment_t w, prev;
        int items, frame_len, frame_no;
        int cfg_w [PHASES]     = '{1, 4095, 4095, 1, -1, 0, -1, 640};
        int cfg_h [PHASES]     = '{1, 4095, 1, 4095, -1, -1, 0, 480};
        int src_pct [PHASES]   = '{0, 85, 0, 23, 0, 85, 0, 23};
        int sink_pct [PHASES]  = '{0, 0, 85, 23, 0, 0, 85, 23};

        img_w = sepc_pkg::SIZE_RESET;
        img_h = sepc_pkg::SIZE_RESET;
        clear_frame();
        prev = '0;

        want_square = '0;
        want_square.found = 1'b1;
        want_square.cx[sepc_pkg::CORNER_TR] = sepc_pkg::SIZE_RESET;
        want_square.cx[sepc_pkg::CORNER_BR] = sepc_pkg::SIZE_RESET;
        want_square.cy[sepc_pkg::CORNER_BR] = sepc_pkg::SIZE_RESET;
        want_square.cy[sepc_pkg::CORNER_BL] = sepc_pkg::SIZE_RESET;

        add_row(5, 6, 7, 8, 1'b1, 1'b1, '0);
        add_row(100, 100, 300, 300, 1'b0, 1'b0, '0);
        add_row(10, 390, 390, 10, 1'b0, 1'b0, '0);
        add_row(0, 0, 400, 400, 1'b1, 1'b1, '0);
        add_row(0, 0, 400, 0, 1'b0, 1'b0, '0);
        add_row(400, 400, 0, 400, 1'b0, 1'b0, '0);
        add_row(0, 0, 400, 0, 1'b0, 1'b0, '0);
        add_row(1, 1, 399, 399, 1'b1, 1'b1, want_square);
        add_row(0, 0, 4095, 4095, 1'b0, 1'b0, '0);
        add_row(4095, 0, 0, 4095, 1'b0, 1'b0, '0);
        add_row(4095, 4095, 4095, 4095, 1'b0, 1'b0, '0);
        add_row(0, 4095, 4095, 0, 1'b1, 1'b0, '0);
        add_row(200, 200, 200, 200, 1'b0, 1'b0, '0);
        add_row(200, 200, 200, 200, 1'b0, 1'b0, '0);
        add_row(0, 400, 400, 0, 1'b0, 1'b0, '0);
        add_row(400, 0, 0, 400, 1'b0, 1'b0, '0);
        add_row(2048, 1365, 682, 2730, 1'b0, 1'b0, '0);
        add_row(4095, 0, 0, 0, 1'b1, 1'b0, '0);

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[i]) send_word(directed[i].w, directed[i].typed, directed[i].want);
        drain(SETTLE_CYCLES);

        for (int phase = 0; phase < PHASES; phase++) begin
            write_reg(sepc_pkg::REG_IMAGE_WIDTH,
                      sepc_pkg::coord_t'(cfg_w[phase] < 0 ? $urandom_range(1, 4095)
                                                          : cfg_w[phase]));
            write_reg(sepc_pkg::REG_IMAGE_HEIGHT,
                      sepc_pkg::coord_t'(cfg_h[phase] < 0 ? $urandom_range(1, 4095)
                                                          : cfg_h[phase]));
            write_reg(REG_SPARE_LO, sepc_pkg::coord_t'($urandom_range(4095)));
            write_reg(REG_SPARE_HI, sepc_pkg::coord_t'($urandom_range(4095)));
            src_idle_pct = src_pct[phase];
            sink_stall_pct = sink_pct[phase];
            items = 0;
            frame_no = 0;
            while (items < ITEMS_PER_PHASE) begin
                case ($urandom_range(9))
                    0: frame_len = $urandom_range(1, 3);
                    1: frame_len = $urandom_range(8, 14);
                    default: frame_len = $urandom_range(4, 7);
                endcase
                for (int k = 0; k < frame_len; k++) begin
                    if (k > 0 && $urandom_range(7) == 0) begin
                        w = prev;
                    end else begin
                        w.sx = pick_coord(img_w);
                        w.sy = pick_coord(img_h);
                        w.ex = pick_coord(img_w);
                        w.ey = pick_coord(img_h);
                    end
                    w.last = (k == frame_len - 1);
                    send_word(w, 1'b0, '0);
                    prev = w;
                    items++;
                end
                frame_no++;
                if (frame_no % 16 == 0) drain(0);
            end
            drain(SETTLE_CYCLES);
        end

        if (errors == 0) begin
            $display("segment_endpoint_corner_picker test passed");
        end else begin
            $display("segment_endpoint_corner_picker test failed");
        end
        $finish;
    end
endmodule
